// File: rtl/esu_pkg.sv
// ----------------------------------------------------------------------------
// esu_pkg
// Shared types, character codes and helpers of the escape sequence unescaper.
// ----------------------------------------------------------------------------
package esu_pkg;

	localparam int BYTE_W  = 8;
	localparam int MAX_RES = 4;
	localparam int CNT_W   = $clog2(MAX_RES + 1);
	localparam int IDX_W   = $clog2(MAX_RES);

	// parser phases
	localparam logic [2:0] MODE_START   = 3'd0;
	localparam logic [2:0] MODE_MAYBE_M = 3'd1;
	localparam logic [2:0] MODE_AFTER_M = 3'd2;
	localparam logic [2:0] MODE_SKIP_WS = 3'd3;
	localparam logic [2:0] MODE_NORMAL  = 3'd4;
	localparam logic [2:0] MODE_BSLASH  = 3'd5;
	localparam logic [2:0] MODE_OCTAL   = 3'd6;
	localparam logic [2:0] MODE_CARET   = 3'd7;

	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CH_BEL    = 8'h07;
	localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DASH   = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_SEVEN  = 8'h37;
	localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3F;
	localparam logic [BYTE_W-1:0] CH_AT     = 8'h40;
	localparam logic [BYTE_W-1:0] CH_UP_E   = 8'h45;
	localparam logic [BYTE_W-1:0] CH_UP_M   = 8'h4D;
	localparam logic [BYTE_W-1:0] CH_UP_X   = 8'h58;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_CARET  = 8'h5E;
	localparam logic [BYTE_W-1:0] CH_LO_A   = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LO_B   = 8'h62;
	localparam logic [BYTE_W-1:0] CH_LO_E   = 8'h65;
	localparam logic [BYTE_W-1:0] CH_LO_N   = 8'h6E;
	localparam logic [BYTE_W-1:0] CH_LO_R   = 8'h72;
	localparam logic [BYTE_W-1:0] CH_LO_T   = 8'h74;
	localparam logic [BYTE_W-1:0] CH_LO_X   = 8'h78;
	localparam logic [BYTE_W-1:0] CH_LO_Z   = 8'h7A;
	localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7F;
	localparam logic [BYTE_W-1:0] CASE_OFS  = 8'h20;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              string_end;
		logic              no_data;
	} esu_result_t;

	// results caused by one request, slot 0 goes out first
	typedef struct packed {
		esu_result_t [MAX_RES-1:0] res;
		logic [CNT_W-1:0]          count;
	} esu_batch_t;

	function automatic logic is_octal(input logic [BYTE_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_SEVEN);
	endfunction

	function automatic logic is_space(input logic [BYTE_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic [BYTE_W-1:0] escape_map(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		case (c)
			CH_LO_A: r = CH_BEL;
			CH_LO_B: r = CH_BS;
			CH_LO_E: r = CH_ESC;
			CH_UP_E: r = CH_ESC;
			CH_LO_N: r = CH_LF;
			CH_LO_R: r = CH_CR;
			CH_LO_T: r = CH_TAB;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/esu_in_if.sv
// ----------------------------------------------------------------------------
// esu_in_if
// Input channel: one string character per request with its last flag.
// ----------------------------------------------------------------------------
interface esu_in_if import esu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              last_byte;

	modport source (output valid, output in_byte, output last_byte, input ready);
	modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

// File: rtl/esu_out_if.sv
// ----------------------------------------------------------------------------
// esu_out_if
// Output channel: one unescaped character per request with end and empty flags.
// ----------------------------------------------------------------------------
interface esu_out_if import esu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              string_end;
	logic              no_data;

	modport source (output valid, output out_byte, output string_end, output no_data,
		input ready);
	modport sink (input valid, input out_byte, input string_end, input no_data,
		output ready);
endinterface

// File: rtl/esu_parser.sv
// ----------------------------------------------------------------------------
// esu_parser
// Escape parser state and the single-pass decode of one character into a
// batch of up to four results, one output byte held back across requests.
// ----------------------------------------------------------------------------
module esu_parser import esu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] c,
	input  logic              last,
	output esu_batch_t        batch
);

	logic [2:0]        mode_q;
	logic [BYTE_W-1:0] oct_val_q;
	logic [1:0]        oct_cnt_q;
	logic              meta_q;
	logic [BYTE_W-1:0] held_q;
	logic              held_valid_q;

	logic [2:0]        mode_d;
	logic [BYTE_W-1:0] oct_val_d;
	logic [1:0]        oct_cnt_d;
	logic              meta_d;
	logic [BYTE_W-1:0] held_d;
	logic              held_valid_d;

	logic              e1_v, e2_v, e3_v, do_plain;
	logic [BYTE_W-1:0] e1_b, e2_b, e3_b, upper;
	logic [BYTE_W-1:0] seq [MAX_RES];
	logic [CNT_W-1:0]  sn;
	logic [IDX_W-1:0]  tail_idx;
	logic              tail_cr;

	always_comb begin
		mode_d    = mode_q;
		oct_val_d = oct_val_q;
		oct_cnt_d = oct_cnt_q;
		meta_d    = meta_q;
		e1_v      = 1'b0;
		e1_b      = CH_NUL;
		e2_v      = 1'b0;
		e2_b      = CH_NUL;
		e3_v      = 1'b0;
		e3_b      = CH_NUL;
		do_plain  = 1'b0;
		upper     = ((c >= CH_LO_A) && (c <= CH_LO_Z)) ? c - CASE_OFS : c;

		if ((mode_q == MODE_OCTAL) && (oct_cnt_q == 2'd1) && is_octal(c)) begin
			oct_val_d = {oct_val_q[BYTE_W-4:0], c[2:0]};
			oct_cnt_d = 2'd2;
		end else begin
			case (mode_q)
				MODE_START: begin
					if (c == CH_UP_M)
						mode_d = MODE_MAYBE_M;
					else
						do_plain = 1'b1;
				end
				MODE_MAYBE_M: begin
					e1_v = 1'b1;
					if (c == CH_DASH) begin
						e1_b   = CH_ESC;
						mode_d = MODE_AFTER_M;
					end else begin
						e1_b     = CH_UP_M;
						do_plain = 1'b1;
					end
				end
				MODE_AFTER_M: begin
					if ((c == CH_UP_X) || (c == CH_LO_X)) begin
						e1_v   = 1'b1;
						e1_b   = CH_LO_X;
						meta_d = 1'b1;
						mode_d = MODE_SKIP_WS;
					end else begin
						do_plain = 1'b1;
					end
				end
				MODE_SKIP_WS: begin
					do_plain = !is_space(c);
				end
				MODE_BSLASH: begin
					if (is_octal(c)) begin
						oct_val_d = {{(BYTE_W-3){1'b0}}, c[2:0]};
						oct_cnt_d = 2'd1;
						mode_d    = MODE_OCTAL;
					end else begin
						e1_v   = 1'b1;
						e1_b   = escape_map(c);
						mode_d = MODE_NORMAL;
					end
				end
				MODE_OCTAL: begin
					e1_v      = 1'b1;
					oct_val_d = '0;
					oct_cnt_d = 2'd0;
					if (is_octal(c)) begin
						e1_b   = {oct_val_q[BYTE_W-4:0], c[2:0]};
						mode_d = MODE_NORMAL;
					end else begin
						e1_b     = oct_val_q;
						do_plain = 1'b1;
					end
				end
				MODE_CARET: begin
					e1_v   = 1'b1;
					e1_b   = (c == CH_QMARK) ? CH_DEL : upper - CH_AT;
					mode_d = MODE_NORMAL;
				end
				default: begin
					do_plain = 1'b1;
				end
			endcase
		end

		if (do_plain) begin
			if (c == CH_BSLASH)
				mode_d = MODE_BSLASH;
			else if (c == CH_CARET)
				mode_d = MODE_CARET;
			else begin
				e2_v   = 1'b1;
				e2_b   = c;
				mode_d = MODE_NORMAL;
			end
		end

		// flush of an unfinished octal escape or lone M at the end of the string
		if (last && (mode_d == MODE_OCTAL)) begin
			e3_v = 1'b1;
			e3_b = oct_val_d;
		end else if (last && (mode_d == MODE_MAYBE_M)) begin
			e3_v = 1'b1;
			e3_b = CH_UP_M;
		end
	end

	// line up held byte and new emits, the newest one is kept back unless the string ends
	always_comb begin
		for (int i = 0; i < MAX_RES; i++)
			seq[i] = CH_NUL;
		sn = '0;
		if (held_valid_q) begin
			seq[sn[IDX_W-1:0]] = held_q;
			sn = sn + 1'b1;
		end
		if (e1_v) begin
			seq[sn[IDX_W-1:0]] = e1_b;
			sn = sn + 1'b1;
		end
		if (e2_v) begin
			seq[sn[IDX_W-1:0]] = e2_b;
			sn = sn + 1'b1;
		end
		if (e3_v) begin
			seq[sn[IDX_W-1:0]] = e3_b;
			sn = sn + 1'b1;
		end
		tail_idx = IDX_W'(sn - 1'b1);
		tail_cr  = (sn != '0) && (seq[tail_idx] == CH_CR);
		if (last && meta_d && !tail_cr) begin
			seq[sn[IDX_W-1:0]] = CH_CR;
			sn = sn + 1'b1;
		end
		tail_idx = IDX_W'(sn - 1'b1);

		for (int i = 0; i < MAX_RES; i++) begin
			batch.res[i].data       = seq[i];
			batch.res[i].string_end = last && (sn != '0) && (IDX_W'(i) == tail_idx);
			batch.res[i].no_data    = 1'b0;
		end
		held_d       = held_q;
		held_valid_d = held_valid_q;
		if (last) begin
			batch.count = sn;
			if (sn == '0) begin
				batch.res[0].string_end = 1'b1;
				batch.res[0].no_data    = 1'b1;
				batch.count             = CNT_W'(1);
			end
		end else begin
			batch.count = (sn == '0) ? '0 : sn - 1'b1;
			if (sn != '0) begin
				held_d       = seq[tail_idx];
				held_valid_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_START;
			oct_val_q    <= '0;
			oct_cnt_q    <= 2'd0;
			meta_q       <= 1'b0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
		end else if (step && last) begin
			mode_q       <= MODE_START;
			oct_val_q    <= '0;
			oct_cnt_q    <= 2'd0;
			meta_q       <= 1'b0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
		end else if (step) begin
			mode_q       <= mode_d;
			oct_val_q    <= oct_val_d;
			oct_cnt_q    <= oct_cnt_d;
			meta_q       <= meta_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
		end
	end

	a_batch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> batch.count <= CNT_W'(MAX_RES))
		else $error("esu_parser: batch larger than result queue");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> mode_q == MODE_START && !held_valid_q && !meta_q)
		else $error("esu_parser: state not cleared after end of string");

	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |-> batch.count != '0)
		else $error("esu_parser: end of string produced no result");

	a_octal_count: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_OCTAL |-> oct_cnt_q == 2'd1 || oct_cnt_q == 2'd2)
		else $error("esu_parser: octal digit count out of range");

endmodule

// File: rtl/esu_result_queue.sv
// ----------------------------------------------------------------------------
// esu_result_queue
// Result register holding one batch and handing it out one result a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module esu_result_queue import esu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  esu_batch_t  batch,
	output logic        can_load,
	output logic        res_valid,
	input  logic        res_ready,
	output esu_result_t res
);

	esu_result_t [MAX_RES-1:0] res_q;
	logic [CNT_W-1:0]          rem_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      pop;

	assign res_valid = rem_q != '0;
	assign pop       = res_valid && res_ready;
	// a batch may replace the last result in the cycle it leaves
	assign can_load  = (rem_q == '0) || ((rem_q == CNT_W'(1)) && pop);
	assign res       = res_q[idx_q];

	always_ff @(posedge clk) begin
		if (load)
			res_q <= batch.res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= batch.count;
			idx_q <= '0;
		end else if (pop) begin
			rem_q <= rem_q - 1'b1;
			idx_q <= idx_q + 1'b1;
		end
	end

	a_load_safe: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_load)
		else $error("esu_result_queue: batch loaded over pending results");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> rem_q == $past(batch.count) && idx_q == '0)
		else $error("esu_result_queue: wrong count after load");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !load |=> rem_q == $past(rem_q) - 1'b1)
		else $error("esu_result_queue: result lost or repeated");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= CNT_W'(MAX_RES))
		else $error("esu_result_queue: remaining count overflow");

endmodule

// File: rtl/escape_sequence_unescaper_core.sv
// ----------------------------------------------------------------------------
// escape_sequence_unescaper_core
// Backslash, caret and meta escape decoder for a byte stream of strings.
// ----------------------------------------------------------------------------
// in_ch takes one string character per request, last_byte set on the final
// one. out_ch gives the unescaped bytes; string_end marks the last result of
// a string, and a string that decodes to nothing gives a single result with
// no_data set. One decoded byte is held back inside until the next character
// or the end of the string decides whether it is the last.
// A character is registered on acceptance into the input register, and is
// decoded from there into a result register of up to four results once that
// register can take it; its results are then valid on out_ch from the result
// register. A character is taken every cycle while it leaves at most one
// result and the receiver is ready; the output port moves one result per
// cycle while the receiver is ready, so a character with several results
// holds back the next until its last result leaves.
// When the receiver stalls, the result register and the input register fill
// and in_ch.ready drops; nothing is dropped. Reset clears the parser to the
// start of a string and empties both registers.
// ----------------------------------------------------------------------------
module escape_sequence_unescaper_core import esu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	esu_in_if.sink    in_ch,
	esu_out_if.source out_ch
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              advance;
	logic              can_load;
	esu_batch_t        batch;
	esu_result_t       res;

	assign advance     = valid_s1 && can_load;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.ready)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	esu_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.c      (byte_s1),
		.last   (last_s1),
		.batch  (batch)
	);

	esu_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.batch     (batch),
		.can_load  (can_load),
		.res_valid (out_ch.valid),
		.res_ready (out_ch.ready),
		.res       (res)
	);

	assign out_ch.out_byte   = res.data;
	assign out_ch.string_end = res.string_end;
	assign out_ch.no_data    = res.no_data;

	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !can_load |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("core: pending character lost while result register busy");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.no_data |-> out_ch.string_end)
		else $error("core: empty marker without end of string");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ch.ready)
		else $error("core: input stalled with empty input register");

endmodule
